// ===== hdl/line_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Simulation builds get concurrent checks; SYNTH builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define LR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LR_ASSERT_IMPL(label, ante, cons, msg)
`define LR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/lr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer package
// Field widths, register codes and the framebuffer index function.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int unsigned FRAME_WIDTH = 1024;

    localparam int unsigned COORD_W     = 10;
    localparam int unsigned COLOR_W     = 8;
    localparam int unsigned INDEX_W     = 22;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned COMPONENTS  = 3;

    localparam int unsigned PROD_W = 2 * COORD_W;
    localparam int unsigned CNT_W  = $clog2(COORD_W + 1);

    // x + FRAME_WIDTH*y, then times the component count
    localparam int unsigned LINEAR_W   = $clog2(FRAME_WIDTH) + COORD_W + 1;
    localparam int unsigned IDX_FULL_W = LINEAR_W + $clog2(COMPONENTS) + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_X_START,
        REG_Y_START,
        REG_X_END,
        REG_Y_END,
        REG_RED,
        REG_GREEN,
        REG_BLUE
    } cfg_reg_t;

    function automatic logic [INDEX_W-1:0] pixel_index(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        logic [LINEAR_W-1:0]   linear;
        logic [IDX_FULL_W-1:0] full;
        linear = LINEAR_W'(x) + LINEAR_W'(FRAME_WIDTH) * LINEAR_W'(y);
        full   = IDX_FULL_W'(linear) * IDX_FULL_W'(COMPONENTS);
        return INDEX_W'(full);
    endfunction

endpackage

// ===== hdl/lr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer channels
// Valid/ready interfaces for step requests, pixels and register writes.
// ----------------------------------------------------------------------------
interface lr_step_if import lr_pkg::*;;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink   (input valid, input advance, output ready);
endinterface

interface lr_pixel_if import lr_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [INDEX_W-1:0] buffer_index;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               last_pixel;

    modport source (
        output valid, output pixel_x, output pixel_y, output buffer_index,
        output out_red, output out_green, output out_blue, output last_pixel,
        input  ready
    );
    modport sink (
        input  valid, input pixel_x, input pixel_y, input buffer_index,
        input  out_red, input out_green, input out_blue, input last_pixel,
        output ready
    );
endinterface

interface lr_cfg_if import lr_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer
// Steps one pixel of a configured straight line per request.
// ----------------------------------------------------------------------------
// Usage:
//   cfg   - register writes (index, data), always ready. Write only while idle:
//           no request under way and no pixel waiting on the pixel channel.
//   step  - one transfer per request. advance low yields no pixel. A backward
//           line (x_end < x_start) yields no pixel and drops the line.
//   pixel - one transfer per accepted request with advance high on a forward
//           or vertical line: column, interpolated row, framebuffer index of
//           the red byte, colour, and last_pixel on the end column. The request
//           after the last pixel starts the line again at x_start.
//   A pixel-producing request runs through MUL, DIV, ROW and EMIT; a vertical
//   line skips DIV. The row division runs on one restoring divider at one
//   quotient bit per cycle. Step is ready again the cycle after the pixel is
//   loaded, so a new request is taken only once the last one is through.
//   Requests without a pixel leave the sequencer in idle.
//   Stall: a pixel waits in the output register while the receiver stalls;
//   the next request is still taken, and its pixel holds in the sequencer
//   until the output register frees up.
//   Reset: configuration registers clear to zero, the line restarts at x_start, no pixel.
// ----------------------------------------------------------------------------
`include "line_rasterizer_defines.svh"

module line_rasterizer import lr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lr_cfg_if.sink        cfg,
    lr_step_if.sink       step,
    lr_pixel_if.source    pixel
);

    typedef enum logic [2:0] {
        ST_IDLE,    // wait for a request
        ST_MUL,     // form dy * (x - x_start), launch the divider
        ST_DIV,     // divider iterates
        ST_ROW,     // apply the signed quotient to y_start
        ST_EMIT     // load the output register
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [COORD_W-1:0] x_start_reg;
    logic [COORD_W-1:0] y_start_reg;
    logic [COORD_W-1:0] x_end_reg;
    logic [COORD_W-1:0] y_end_reg;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;

    // line progress
    logic [COORD_W-1:0] column_reg;
    logic               active_reg;

    // per-pixel working registers
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] t_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic               neg_reg;
    logic               vertical_reg;
    logic               last_reg;
    logic [COORD_W-1:0] y_reg;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [COLOR_W-1:0] out_red_reg;
    logic [COLOR_W-1:0] out_green_reg;
    logic [COLOR_W-1:0] out_blue_reg;
    logic               out_last_reg;

    logic               step_fire;
    logic               backward;
    logic               start_line;
    logic [COORD_W-1:0] x_pick;
    logic [COORD_W-1:0] x_sel;
    logic               div_start;
    logic [PROD_W-1:0]  div_dividend;
    logic               div_done;
    logic [COORD_W-1:0] div_quotient;
    logic [COORD_W-1:0] q_sel;
    logic               out_free;
    logic               out_load;

    assign cfg.ready  = 1'b1;
    assign step.ready = (state_reg == ST_IDLE);
    assign step_fire  = step.valid && step.ready;
    assign backward   = (x_end_reg < x_start_reg);
    assign start_line = step_fire && step.advance && !backward;

    // resume the line, or restart it when the column fell outside the span
    assign x_pick = active_reg ? column_reg : x_start_reg;
    assign x_sel  = (x_pick < x_start_reg || x_pick > x_end_reg) ? x_start_reg : x_pick;

    // one multiply ahead of the divider's input register
    assign div_start    = (state_reg == ST_MUL) && !vertical_reg;
    assign div_dividend = PROD_W'(dy_reg) * PROD_W'(t_reg);

    lr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dx_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // a vertical line never runs the divider: its row is y_start
    assign q_sel    = vertical_reg ? '0 : div_quotient;
    assign out_free = !out_valid_reg || pixel.ready;
    assign out_load = (state_reg == ST_EMIT) && out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg <= '0;
            y_start_reg <= '0;
            x_end_reg   <= '0;
            y_end_reg   <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_X_START: x_start_reg <= cfg.data[COORD_W-1:0];
                REG_Y_START: y_start_reg <= cfg.data[COORD_W-1:0];
                REG_X_END:   x_end_reg   <= cfg.data[COORD_W-1:0];
                REG_Y_END:   y_end_reg   <= cfg.data[COORD_W-1:0];
                REG_RED:     red_reg     <= cfg.data[COLOR_W-1:0];
                REG_GREEN:   green_reg   <= cfg.data[COLOR_W-1:0];
                REG_BLUE:    blue_reg    <= cfg.data[COLOR_W-1:0];
                default:     ;
            endcase
        end
    end

    // sequencer, line progress and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            column_reg    <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load a new pixel, or drop the old one once the receiver takes it
            out_valid_reg <= out_load || (out_valid_reg && !pixel.ready);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (step_fire && step.advance)
                    begin
                        if (backward)
                        begin
                            active_reg <= 1'b0;
                        end
                        else
                        begin
                            // advance the column now; the pixel follows
                            if (x_sel == x_end_reg)
                            begin
                                active_reg <= 1'b0;
                                column_reg <= '0;
                            end
                            else
                            begin
                                active_reg <= 1'b1;
                                column_reg <= x_sel + 1'b1;
                            end
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= vertical_reg ? ST_ROW : ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_ROW;
                    end
                end
                ST_ROW:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    // hold until the output register frees up
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        if (start_line)
        begin
            x_reg        <= x_sel;
            t_reg        <= x_sel - x_start_reg;
            dx_reg       <= x_end_reg - x_start_reg;
            vertical_reg <= (x_end_reg == x_start_reg);
            last_reg     <= (x_sel == x_end_reg);
            neg_reg      <= (y_end_reg < y_start_reg);
            dy_reg       <= (y_end_reg < y_start_reg) ? (y_start_reg - y_end_reg)
                                                      : (y_end_reg - y_start_reg);
        end

        if (state_reg == ST_ROW)
        begin
            y_reg <= neg_reg ? (y_start_reg - q_sel) : (y_start_reg + q_sel);
        end

        if (out_load)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_index_reg <= pixel_index(x_reg, y_reg);
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.pixel_x      = out_x_reg;
    assign pixel.pixel_y      = out_y_reg;
    assign pixel.buffer_index = out_index_reg;
    assign pixel.out_red      = out_red_reg;
    assign pixel.out_green    = out_green_reg;
    assign pixel.out_blue     = out_blue_reg;
    assign pixel.last_pixel   = out_last_reg;

    // a pixel-producing request must leave idle
    `LR_ASSERT_NEXT(a_start_busy, start_line, state_reg != ST_IDLE, "request lost in idle")
    // the end flag only ever marks the end column
    `LR_ASSERT_IMPL(a_last_column, pixel.valid && pixel.last_pixel, pixel.pixel_x == x_end_reg, "last pixel off the end column")
    // an interpolated row lies between the two end rows
    `LR_ASSERT_IMPL(a_row_span, pixel.valid, (pixel.pixel_y >= y_start_reg && pixel.pixel_y <= y_end_reg) || (pixel.pixel_y <= y_start_reg && pixel.pixel_y >= y_end_reg), "row outside the line span")

endmodule

// ===== hdl/lr_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer divider
// Restoring divider, one quotient bit per cycle, for quotients below 2**COORD_W.
// ----------------------------------------------------------------------------
module lr_divider import lr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [PROD_W-1:0]  dividend,
    input  logic [COORD_W-1:0] divisor,
    output logic               done,
    output logic [COORD_W-1:0] quotient
);

    logic [COORD_W-1:0] rem_reg;
    logic [COORD_W-1:0] low_reg;
    logic [COORD_W-1:0] quo_reg;
    logic [COORD_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [COORD_W:0]   trial;
    logic               fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, low_reg[COORD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // flag the cycle after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(COORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // upper half is below the divisor, so COORD_W steps suffice
            rem_reg <= dividend[PROD_W-1:COORD_W];
            low_reg <= dividend[COORD_W-1:0];
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? COORD_W'(trial - {1'b0, dvs_reg}) : trial[COORD_W-1:0];
            low_reg <= {low_reg[COORD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[COORD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== tb/tb_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Programs line endpoints and colours, issues step requests and checks every
// pixel against a built-in line predictor, under varied flow-control patterns.
// ----------------------------------------------------------------------------
module tb_line_rasterizer;
    import lr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 800000;
    localparam int unsigned STEP_TARGET  = 1700;
    localparam int unsigned SETTLE       = 20;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PRINT_CAP    = 40;

    // Flow-control pattern of the current phase
    typedef enum int unsigned {
        FLOW_FREE,
        FLOW_SLOW_SOURCE,
        FLOW_SLOW_SINK,
        FLOW_BOTH
    } flow_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [INDEX_W-1:0] buf_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lr_cfg_if   cfg_ch ();
    lr_step_if  step_ch ();
    lr_pixel_if pixel_ch ();

    line_rasterizer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .step  (step_ch),
        .pixel (pixel_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Line predictor: own copy of the registers and the stepping state
    // ------------------------------------------------------------------------
    logic [COORD_W-1:0] line_x0, line_y0, line_x1, line_y1;
    logic [COLOR_W-1:0] colour_r, colour_g, colour_b;
    logic [COORD_W-1:0] next_column = '0;
    logic               line_open = 1'b0;

    pixel_t pending_pixels[$];   // pixels owed by the block, oldest first
    logic   step_backlog[$];     // advance bits waiting for the driver

    flow_t       flow_mode = FLOW_FREE;
    logic        hold_rx = 1'b0;
    int unsigned useful_steps = 0;
    int unsigned steps_taken = 0;
    int unsigned pixels_checked = 0;
    int unsigned line_ends_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    task automatic apply_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        case (which)
            REG_X_START: line_x0  = value;
            REG_Y_START: line_y0  = value;
            REG_X_END:   line_x1  = value;
            REG_Y_END:   line_y1  = value;
            REG_RED:     colour_r = value[COLOR_W-1:0];
            REG_GREEN:   colour_g = value[COLOR_W-1:0];
            REG_BLUE:    colour_b = value[COLOR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Work out the pixel that one accepted request produces, if any
    task automatic step_line(input logic adv);
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        int unsigned        run;
        int unsigned        slope_prod;
        int unsigned        full_index;
        pixel_t             want;
        if (!adv)
            return;
        // Backward line: drop the line, emit nothing
        if (line_x1 < line_x0)
        begin
            line_open = 1'b0;
            return;
        end
        col = line_open ? next_column : line_x0;
        // Restart when the registers moved the line away from the column
        if (col < line_x0 || col > line_x1)
            col = line_x0;
        run = line_x1 - line_x0;
        if (run == 0)
            row = line_y0;
        else if (line_y1 >= line_y0)
        begin
            slope_prod = (32'(line_y1) - 32'(line_y0)) * (32'(col) - 32'(line_x0));
            row = line_y0 + COORD_W'(slope_prod / run);
        end
        else
        begin
            slope_prod = (32'(line_y0) - 32'(line_y1)) * (32'(col) - 32'(line_x0));
            row = line_y0 - COORD_W'(slope_prod / run);
        end
        full_index = (32'(col) + 32'(FRAME_WIDTH) * 32'(row)) * 32'(COMPONENTS);
        want.x         = col;
        want.y         = row;
        want.buf_index = full_index[INDEX_W-1:0];
        want.red       = colour_r;
        want.green     = colour_g;
        want.blue      = colour_b;
        want.last      = (col == line_x1);
        pending_pixels.push_back(want);
        if (want.last)
        begin
            line_open   = 1'b0;
            next_column = '0;
        end
        else
        begin
            line_open   = 1'b1;
            next_column = col + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("pixel %0d %s got %0d want %0d",
                                      pixels_checked, name, got, want));
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pending_pixels.size() == 0)
        begin
            report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                                      pixel_ch.pixel_x, pixel_ch.pixel_y));
            return;
        end
        want = pending_pixels.pop_front();
        check_field("pixel_x",      pixel_ch.pixel_x,      want.x);
        check_field("pixel_y",      pixel_ch.pixel_y,      want.y);
        check_field("buffer_index", pixel_ch.buffer_index, want.buf_index);
        check_field("out_red",      pixel_ch.out_red,      want.red);
        check_field("out_green",    pixel_ch.out_green,    want.green);
        check_field("out_blue",     pixel_ch.out_blue,     want.blue);
        check_field("last_pixel",   pixel_ch.last_pixel,   want.last);
        if (want.last)
            line_ends_seen++;
        pixels_checked++;
    endtask

    function automatic bit roll(input int unsigned percent);
        return $urandom_range(0, 99) < percent;
    endfunction

    // ------------------------------------------------------------------------
    // Step driver: hold valid until the transfer, then take the next request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ch.valid   <= 1'b0;
            step_ch.advance <= 1'b0;
        end
        else
        begin
            if (step_ch.valid && step_ch.ready)
            begin
                step_line(step_ch.advance);
                steps_taken++;
            end
            // Offer a new request only once the current one is gone
            if (!step_ch.valid || step_ch.ready)
            begin
                if (step_backlog.size() != 0 &&
                    !(flow_mode == FLOW_SLOW_SOURCE && roll(81)) &&
                    !(flow_mode == FLOW_BOTH && roll(28)))
                begin
                    step_ch.valid   <= 1'b1;
                    step_ch.advance <= step_backlog.pop_front();
                end
                else
                    step_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel monitor: check each transfer, stall at random per the flow pattern
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_ch.ready <= 1'b0;
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                check_pixel();
            pixel_ch.ready <= !hold_rx &&
                              !(flow_mode == FLOW_SLOW_SINK && roll(81)) &&
                              !(flow_mode == FLOW_BOTH && roll(28));
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pending_pixels.size());
            $display("tb_line_rasterizer NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Register writes run on rising edges; queue pushes and
    // control flags change on falling edges, clear of the clocked blocks.
    // ------------------------------------------------------------------------
    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= which;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_reg(which, value);
    endtask

    task automatic set_line(input int unsigned x0, input int unsigned y0,
                            input int unsigned x1, input int unsigned y1);
        @(posedge clk);
        write_reg(REG_X_START, CFG_DATA_W'(x0));
        write_reg(REG_Y_START, CFG_DATA_W'(y0));
        write_reg(REG_X_END,   CFG_DATA_W'(x1));
        write_reg(REG_Y_END,   CFG_DATA_W'(y1));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_colour(input int unsigned r, input int unsigned g,
                              input int unsigned b);
        @(posedge clk);
        write_reg(REG_RED,   CFG_DATA_W'(r));
        write_reg(REG_GREEN, CFG_DATA_W'(g));
        write_reg(REG_BLUE,  CFG_DATA_W'(b));
        cfg_ch.valid <= 1'b0;
    endtask

    // Push requests; count only those that can yield a pixel
    task automatic queue_steps(input int unsigned count, input int unsigned skip_percent);
        logic adv;
        @(negedge clk);
        repeat (count)
        begin
            adv = !roll(skip_percent);
            step_backlog.push_back(adv);
            if (adv && line_x1 >= line_x0)
                useful_steps++;
        end
    endtask

    // Block until every request is taken and every pixel has come back
    task automatic wait_idle(input int unsigned settle);
        @(negedge clk);
        while (step_backlog.size() != 0 || step_ch.valid || pending_pixels.size() != 0)
            @(negedge clk);
        repeat (settle)
            @(negedge clk);
    endtask

    function automatic int unsigned pick_row();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 1023;
        return $urandom_range(0, 1023);
    endfunction

    task automatic pick_random_line();
        int unsigned shape;
        int unsigned x0;
        int unsigned x1;
        int unsigned span;
        shape = $urandom_range(0, 99);
        x0 = $urandom_range(0, 1023);
        if (shape < 60)
        begin
            // Short forward line
            span = $urandom_range(1, 12);
            x1 = (x0 + span > 1023) ? 1023 : x0 + span;
        end
        else if (shape < 70)
            x1 = x0;
        else if (shape < 80)
        begin
            x0 = $urandom_range(1, 1023);
            x1 = $urandom_range(0, x0 - 1);
        end
        else if (shape < 92)
            x1 = $urandom_range(0, 1023);
        else
        begin
            x0 = roll(50) ? 0 : x0;
            x1 = 1023;
        end
        set_line(x0, pick_row(), x1, pick_row());
    endtask

    // Long receiver hold-off while requests keep coming, then a drained pause
    task automatic stress_backpressure();
        int unsigned x0;
        flow_mode = FLOW_FREE;
        x0 = $urandom_range(0, 1000);
        set_line(x0, pick_row(), x0 + $urandom_range(8, 12), pick_row());
        queue_steps(14, 0);
        @(negedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES)
            @(negedge clk);
        hold_rx = 1'b0;
        wait_idle(SETTLE);
        queue_steps(5, 0);
        wait_idle(0);
        queue_steps(5, 0);
        wait_idle(SETTLE);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned phase;
        int unsigned len;
        int unsigned count;
        int unsigned drain_wait;

        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_X_START;
        cfg_ch.data     = '0;

        line_x0 = '0; line_y0 = '0; line_x1 = '0; line_y1 = '0;
        colour_r = '0; colour_g = '0; colour_b = '0;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers give a vertical line at the origin;
        // a cleared advance yields nothing
        @(negedge clk);
        step_backlog.push_back(1'b1);
        step_backlog.push_back(1'b0);
        step_backlog.push_back(1'b1);
        wait_idle(SETTLE);

        // Right edge, full-height rise, then wrap back to the start
        set_line(1020, 0, 1023, 1023);
        set_colour(255, 0, 170);
        queue_steps(5, 0);
        wait_idle(SETTLE);

        // Full-width falling line, left mid-way
        set_line(0, 1023, 1023, 0);
        set_colour(0, 255, 85);
        queue_steps(3, 0);
        wait_idle(SETTLE);

        // Backward line: nothing out, line dropped
        set_line(500, 7, 10, 9);
        queue_steps(2, 0);
        wait_idle(SETTLE);

        // Vertical line at the far corner
        set_line(1023, 1023, 1023, 0);
        queue_steps(2, 0);
        wait_idle(SETTLE);

        // Shallow falling slope, division truncates toward zero
        set_line(3, 5, 9, 2);
        set_colour(1, 128, 254);
        queue_steps(8, 0);
        wait_idle(SETTLE);

        // Random phases: mostly complete short lines, some long, vertical,
        // backward, and colour-only changes that leave the line under way
        phase = 0;
        while (useful_steps < STEP_TARGET)
        begin
            flow_mode = flow_t'(phase % 4);
            if (phase % 60 == 17)
                stress_backpressure();
            else
            begin
                if (roll(25))
                    set_colour($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
                else
                begin
                    pick_random_line();
                    if (roll(50))
                        set_colour($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255));
                end
                len = (line_x1 >= line_x0) ? line_x1 - line_x0 + 1 : 0;
                if (len != 0 && len <= 13)
                    count = $urandom_range(1, 2 * len + 2);
                else
                    count = $urandom_range(1, 16);
                queue_steps(count, 10);
                wait_idle(SETTLE);
            end
            phase++;
        end

        // Final drain with a bound; anything still owed is a failure
        drain_wait = 0;
        while ((step_backlog.size() != 0 || step_ch.valid || pending_pixels.size() != 0) &&
               drain_wait < 20000)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (SETTLE)
            @(negedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));

        $display("covered %0d line phases, %0d register writes, %0d step transfers",
                 phase + 6, reg_writes, steps_taken);
        $display("checked %0d pixels, %0d line ends, %0d mismatches",
                 pixels_checked, line_ends_seen, mismatches);
        if (mismatches == 0)
            $display("tb_line_rasterizer OK");
        else
            $display("tb_line_rasterizer NOT OK");
        $finish;
    end

endmodule
